@@ hdl/fen_pkg.sv @@
`timescale 1ns / 1ps
// fen_pkg: types, codes and character constants for the FEN parser.
// No dependencies; imported by fen_step, fen_out_reg and fen_position_parser.

package fen_pkg;

    localparam int FULLMOVE_BITS  = 16;
    localparam int FULLMOVE_OUT_W = 16;
    localparam int FM_EXT_BITS    = FULLMOVE_BITS + 4;
    localparam logic [FULLMOVE_BITS-1:0] FM_MAX = {FULLMOVE_BITS{1'b1}};

    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 56;
    localparam int TUSER_OUT_W = 2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_H  = 8'h68;
    localparam logic [7:0] CH_LC_W  = 8'h77;

    localparam logic [3:0] FILES_PER_RANK = 4'd8;
    localparam logic [2:0] TOP_RANK       = 3'd7;
    localparam logic [2:0] CASTLE_DONE    = 3'd4;
    localparam logic [2:0] EP_RANK_WHITE  = 3'd2;
    localparam logic [2:0] EP_RANK_BLACK  = 3'd5;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_LEAD,
        PH_BOARD,
        PH_STM,
        PH_SP_STM,
        PH_CASTLE,
        PH_EP_FIRST,
        PH_EP_RANK,
        PH_SP_EP,
        PH_HALF_FIRST,
        PH_HALF_SECOND,
        PH_SP_HALF,
        PH_FULL_FIRST,
        PH_FULL_MORE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PLACE   = 2'd0,
        KIND_SUMMARY = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_SYMBOL    = 4'd1,
        ERR_FILES     = 4'd2,
        ERR_SEPARATOR = 4'd3,
        ERR_SPACE     = 4'd4,
        ERR_COLOR     = 4'd5,
        ERR_CASTLE    = 4'd6,
        ERR_EPFILE    = 4'd7,
        ERR_EPRANK    = 4'd8,
        ERR_HALFMOVE  = 4'd9,
        ERR_FULLMOVE  = 4'd10,
        ERR_EARLY_END = 4'd11
    } err_t;

    typedef struct packed {
        phase_t                   phase;
        logic [3:0]               file_cnt;
        logic [2:0]               rank_cnt;
        logic                     side;
        logic [3:0]               castle;
        logic [2:0]               castle_next;
        logic                     ep_present;
        logic [2:0]               ep_file;
        logic                     ep_rank6;
        logic [6:0]               halfmove;
        logic [FULLMOVE_BITS-1:0] fullmove;
        logic                     sat;
    } fen_state_t;

    typedef struct packed {
        kind_t                     kind;
        logic [5:0]                square;
        logic [3:0]                piece;
        logic                      side;
        logic [3:0]                castle;
        logic                      ep_present;
        logic [5:0]                ep_square;
        logic [6:0]                halfmove;
        logic [FULLMOVE_OUT_W-1:0] fullmove;
        logic                      sat;
        err_t                      err;
    } fen_result_t;

    localparam fen_state_t STATE_CLEAR = '{
        phase:       PH_IDLE,
        file_cnt:    4'd0,
        rank_cnt:    TOP_RANK,
        side:        1'b0,
        castle:      4'd0,
        castle_next: 3'd0,
        ep_present:  1'b0,
        ep_file:     3'd0,
        ep_rank6:    1'b0,
        halfmove:    7'd0,
        fullmove:    '0,
        sat:         1'b0
    };

    // {found, code}
    function automatic logic [4:0] piece_lookup(input logic [7:0] c);
        logic [4:0] r;
        case (c)
            8'h50:   r = {1'b1, 4'd0};
            8'h4E:   r = {1'b1, 4'd1};
            8'h42:   r = {1'b1, 4'd2};
            8'h52:   r = {1'b1, 4'd3};
            8'h51:   r = {1'b1, 4'd4};
            8'h4B:   r = {1'b1, 4'd5};
            8'h70:   r = {1'b1, 4'd6};
            8'h6E:   r = {1'b1, 4'd7};
            8'h62:   r = {1'b1, 4'd8};
            8'h72:   r = {1'b1, 4'd9};
            8'h71:   r = {1'b1, 4'd10};
            8'h6B:   r = {1'b1, 4'd11};
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    // {found, index}: K Q k q
    function automatic logic [2:0] castle_lookup(input logic [7:0] c);
        logic [2:0] r;
        case (c)
            8'h4B:   r = {1'b1, 2'd0};
            8'h51:   r = {1'b1, 2'd1};
            8'h6B:   r = {1'b1, 2'd2};
            8'h71:   r = {1'b1, 2'd3};
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/fen_step.sv @@
`timescale 1ns / 1ps
// fen_step: combinational update of the parser state for one character.
// Depends on fen_pkg.

module fen_step
    import fen_pkg::*;
(
    input  fen_state_t  st,
    input  logic [7:0]  char_code,
    input  logic        start_req,
    input  logic        text_end,
    output fen_state_t  st_next,
    output logic        res_valid,
    output fen_result_t res
);

    logic                   digit;
    logic [3:0]             dval;
    logic [4:0]             fsum;
    logic [4:0]             pc;
    logic [2:0]             ci;
    logic [FM_EXT_BITS-1:0] fm_ext;
    logic [FM_EXT_BITS-1:0] fm_prod;
    logic                   go_board;
    logic                   quiet;
    logic                   summ;
    logic                   place;
    logic [5:0]             place_sq;
    err_t                   err;
    fen_state_t             s;

    always_comb
    begin
        digit    = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
        dval     = digit ? char_code[3:0] : 4'd0;
        pc       = piece_lookup(char_code);
        ci       = castle_lookup(char_code);
        s        = st;
        go_board = 1'b0;
        quiet    = 1'b0;
        summ     = 1'b0;
        place    = 1'b0;
        place_sq = 6'd0;
        err      = ERR_NONE;
        fsum     = 5'd0;

        if (start_req)
        begin
            s       = STATE_CLEAR;
            s.phase = PH_LEAD;
        end

        fm_ext  = {4'd0, s.fullmove};
        fm_prod = (fm_ext << 3) + (fm_ext << 1) + {{(FM_EXT_BITS-4){1'b0}}, dval};

        case (s.phase)
            PH_IDLE:
            begin
                quiet = 1'b1;
            end
            PH_LEAD:
            begin
                if (char_code != CH_SPACE && char_code != CH_TAB)
                    go_board = 1'b1;
            end
            PH_BOARD:
            begin
                go_board = 1'b1;
            end
            PH_STM:
            begin
                if (char_code == CH_LC_W)
                begin
                    s.side  = 1'b0;
                    s.phase = PH_SP_STM;
                end
                else if (char_code == CH_LC_B)
                begin
                    s.side  = 1'b1;
                    s.phase = PH_SP_STM;
                end
                else
                    err = ERR_COLOR;
            end
            PH_SP_STM:
            begin
                if (char_code != CH_SPACE)
                    err = ERR_SPACE;
                else
                    s.phase = PH_CASTLE;
            end
            PH_CASTLE:
            begin
                if (s.castle_next == 3'd0 && char_code == CH_DASH)
                    s.castle_next = CASTLE_DONE;
                else if (ci[2] && {1'b0, ci[1:0]} >= s.castle_next)
                begin
                    s.castle[ci[1:0]] = 1'b1;
                    s.castle_next     = {1'b0, ci[1:0]} + 3'd1;
                end
                else if (s.castle_next == 3'd0)
                    err = ERR_CASTLE;
                else if (char_code == CH_SPACE)
                    s.phase = PH_EP_FIRST;
                else
                    err = ERR_SPACE;
            end
            PH_EP_FIRST:
            begin
                if (char_code == CH_DASH)
                begin
                    s.ep_present = 1'b0;
                    s.phase      = PH_SP_EP;
                end
                else if (char_code >= CH_LC_A && char_code <= CH_LC_H)
                begin
                    s.ep_file = 3'(char_code - CH_LC_A);
                    s.phase   = PH_EP_RANK;
                end
                else
                    err = ERR_EPFILE;
            end
            PH_EP_RANK:
            begin
                if (char_code == CH_THREE || char_code == CH_SIX)
                begin
                    s.ep_rank6   = (char_code == CH_SIX);
                    s.ep_present = 1'b1;
                    s.phase      = PH_SP_EP;
                end
                else
                    err = ERR_EPRANK;
            end
            PH_SP_EP:
            begin
                if (char_code != CH_SPACE)
                    err = ERR_SPACE;
                else
                    s.phase = PH_HALF_FIRST;
            end
            PH_HALF_FIRST:
            begin
                if (!digit)
                    err = ERR_HALFMOVE;
                else
                begin
                    s.halfmove = {3'd0, dval};
                    s.phase    = (dval == 4'd0) ? PH_SP_HALF : PH_HALF_SECOND;
                end
            end
            PH_HALF_SECOND:
            begin
                if (digit)
                begin
                    s.halfmove = (s.halfmove << 3) + (s.halfmove << 1) + {3'd0, dval};
                    s.phase    = PH_SP_HALF;
                end
                else if (char_code == CH_SPACE)
                    s.phase = PH_FULL_FIRST;
                else
                    err = ERR_SPACE;
            end
            PH_SP_HALF:
            begin
                if (char_code != CH_SPACE)
                    err = ERR_SPACE;
                else
                    s.phase = PH_FULL_FIRST;
            end
            PH_FULL_FIRST:
            begin
                if (!digit)
                    err = ERR_FULLMOVE;
                else
                begin
                    s.fullmove = {{(FULLMOVE_BITS-4){1'b0}}, dval};
                    if (dval == 4'd0 || text_end)
                        summ = 1'b1;
                    else
                        s.phase = PH_FULL_MORE;
                end
            end
            PH_FULL_MORE:
            begin
                if (!digit)
                    summ = 1'b1;
                else
                begin
                    if (s.sat || fm_prod > {4'd0, FM_MAX})
                    begin
                        s.fullmove = FM_MAX;
                        s.sat      = 1'b1;
                    end
                    else
                        s.fullmove = fm_prod[FULLMOVE_BITS-1:0];
                    if (text_end)
                        summ = 1'b1;
                end
            end
            default:
            begin
                s.phase = PH_IDLE;
                quiet   = 1'b1;
            end
        endcase

        if (go_board)
        begin
            s.phase = PH_BOARD;
            if (s.file_cnt >= FILES_PER_RANK)
            begin
                if (s.rank_cnt != 3'd0)
                begin
                    if (char_code != CH_SLASH)
                        err = ERR_SEPARATOR;
                    else
                    begin
                        s.rank_cnt = s.rank_cnt - 3'd1;
                        s.file_cnt = 4'd0;
                    end
                end
                else if (char_code != CH_SPACE)
                    err = ERR_SPACE;
                else
                    s.phase = PH_STM;
            end
            else if (char_code >= CH_ONE && char_code <= CH_EIGHT)
            begin
                fsum = {1'b0, s.file_cnt} + {1'b0, dval};
                if (fsum > {1'b0, FILES_PER_RANK})
                    err = ERR_FILES;
                else
                    s.file_cnt = fsum[3:0];
            end
            else if (!pc[4])
                err = ERR_SYMBOL;
            else
            begin
                place      = 1'b1;
                place_sq   = {s.rank_cnt, s.file_cnt[2:0]};
                s.file_cnt = s.file_cnt + 4'd1;
            end
        end

        if (err == ERR_NONE && !summ && !quiet && text_end)
            err = ERR_EARLY_END;

        res       = '0;
        res.kind  = KIND_PLACE;
        res.err   = ERR_NONE;
        res_valid = 1'b0;
        if (err != ERR_NONE)
        begin
            res_valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.err   = err;
            s.phase   = PH_IDLE;
        end
        else if (summ)
        begin
            res_valid      = 1'b1;
            res.kind       = KIND_SUMMARY;
            res.side       = s.side;
            res.castle     = s.castle;
            res.ep_present = s.ep_present;
            res.ep_square  = s.ep_present ?
                             {(s.ep_rank6 ? EP_RANK_BLACK : EP_RANK_WHITE), s.ep_file} : 6'd0;
            res.halfmove   = s.halfmove;
            res.fullmove   = FULLMOVE_OUT_W'(s.fullmove);
            res.sat        = s.sat;
            s.phase        = PH_IDLE;
        end
        else if (place)
        begin
            res_valid  = 1'b1;
            res.square = place_sq;
            res.piece  = pc[3:0];
        end

        st_next = s;
    end

endmodule

@@ hdl/fen_out_reg.sv @@
`timescale 1ns / 1ps
// fen_out_reg: result register on the master side, packs result fields into beats.
// Depends on fen_pkg.

module fen_out_reg
    import fen_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  logic                   load_valid,
    input  fen_result_t            res,
    output logic                   slot_free,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,   // square, piece, side_to_move, castle_rights,
                                              // ep_present, ep_square, halfmove_clock,
                                              // fullmove_number, fullmove_saturated,
                                              // error_code, zero pad
    output logic [TUSER_OUT_W-1:0] m_tuser    // kind
);

    logic        valid_reg;
    logic        valid_next;
    fen_result_t res_reg;

    assign slot_free  = !valid_reg || m_tready;
    assign valid_next = load ? load_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && load_valid)
            res_reg <= res;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tdata  = {6'd0, res_reg.err, res_reg.sat, res_reg.fullmove, res_reg.halfmove,
                       res_reg.ep_square, res_reg.ep_present, res_reg.castle, res_reg.side,
                       res_reg.piece, res_reg.square};

endmodule

@@ hdl/fen_position_parser.sv @@
`timescale 1ns / 1ps
// fen_position_parser: top level of the streaming FEN record parser.
// Depends on fen_pkg, fen_step and fen_out_reg.

// One character per beat in, at most one result beat out per character. The parser
// sustains one character per clock while the master side does not stall; a character
// is held in the input register, is evaluated against the parse state by a single
// combinational step, and its result is loaded into the output register when the
// output slot is free; the output register drives the result beat on the master side.
// Back-pressure on the master side holds the input register and the parse state; the
// slave side keeps accepting while the input register is empty or moving on.

module fen_position_parser
    import fen_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // char_code
    input  logic                   s_tuser,   // start_req
    input  logic                   s_tlast,   // text_end
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,   // square, piece, side_to_move, castle_rights,
                                              // ep_present, ep_square, halfmove_clock,
                                              // fullmove_number, fullmove_saturated,
                                              // error_code, zero pad
    output logic [TUSER_OUT_W-1:0] m_tuser    // kind
);

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_char_reg;
    logic        in_start_reg;
    logic        in_last_reg;
    logic        slot_free;
    logic        advance;
    logic        step_valid;
    fen_result_t step_res;
    fen_state_t  state_reg;
    fen_state_t  state_next;
    fen_state_t  step_state;

    assign advance  = in_valid_reg && slot_free;
    assign s_tready = !in_valid_reg || slot_free;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_char_reg  <= s_tdata;
            in_start_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
    end

    fen_step u_step (
        .st        (state_reg),
        .char_code (in_char_reg),
        .start_req (in_start_reg),
        .text_end  (in_last_reg),
        .st_next   (step_state),
        .res_valid (step_valid),
        .res       (step_res)
    );

    assign state_next = advance ? step_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_CLEAR;
        else
            state_reg <= state_next;
    end

    fen_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (slot_free),
        .load_valid (advance && step_valid),
        .res        (step_res),
        .slot_free  (slot_free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    // errors and summaries close the record
    a_close_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_valid && step_res.kind != KIND_PLACE) |=> (state_reg.phase == PH_IDLE))
        else $error("record not closed after final beat");

    // no result while idle unless a new record starts
    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !in_start_reg && state_reg.phase == PH_IDLE) |-> !step_valid)
        else $error("result produced while idle");

    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.file_cnt <= FILES_PER_RANK) && (state_reg.castle_next <= CASTLE_DONE))
        else $error("file or castle counter out of range");

    // parse state moves only when a character is consumed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("parse state changed without a character");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking testbench for fen_position_parser, one character per beat.
// Directed table of edge cases, then random FEN records with mutations, checked against
// an in-bench parse predictor. Depends on fen_pkg and fen_position_parser.

module tb
    import fen_pkg::*;
;

    localparam int DIRECTED_ROWS = 20;
    localparam int RANDOM_BEATS  = 1250;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [7:0] ch;
        logic       start;
        logic       last;
        logic       typed;
        kind_t      kind;
        err_t       err;
        logic [5:0] square;
        logic [3:0] piece;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       start;
        logic       last;
    } char_beat_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic [TUSER_OUT_W-1:0] m_tuser;

    fen_result_t pending_results[$];
    char_beat_t  record_beats[$];
    stim_row_t   directed [DIRECTED_ROWS];
    int          mismatch_count = 0;
    int          beats_sent = 0;
    logic        calm;

    string piece_chars  = "PNBRQKpnbrqk";
    string castle_chars = "KQkq";

    // predictor state
    phase_t          ph = PH_IDLE;
    logic [3:0]      files = 4'd0;
    logic [2:0]      rank = TOP_RANK;
    logic            side = 1'b0;
    logic [3:0]      castle = 4'd0;
    logic [2:0]      castle_nxt = 3'd0;
    logic            ep_on = 1'b0;
    logic [2:0]      ep_file = 3'd0;
    logic [2:0]      ep_rank = 3'd0;
    logic [6:0]      half = 7'd0;
    longint unsigned full = 0;
    logic            full_sat = 1'b0;

    assign calm = (beats_sent >= 500) && (beats_sent < 800);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    fen_position_parser u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    task automatic predict_fen_char(input logic [7:0] c, input logic st, input logic la,
                                    output bit emit, output fen_result_t r);
        bit              is_dig;
        bit              placed;
        bit              sum;
        err_t            e;
        int unsigned     dv;
        longint unsigned v;
        int              hit;
        int              k;
        logic [5:0]      sq;
        logic [3:0]      pc;
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
        dv     = is_dig ? int'(c - CH_ZERO) : 0;
        placed = 1'b0;
        sum    = 1'b0;
        e      = ERR_NONE;
        sq     = '0;
        pc     = '0;
        emit   = 1'b0;
        r      = '0;
        if (st)
        begin
            files      = 4'd0;
            rank       = TOP_RANK;
            side       = 1'b0;
            castle     = 4'd0;
            castle_nxt = 3'd0;
            ep_on      = 1'b0;
            ep_file    = 3'd0;
            ep_rank    = 3'd0;
            half       = 7'd0;
            full       = 0;
            full_sat   = 1'b0;
            ph         = PH_LEAD;
        end
        if (ph != PH_IDLE)
        begin
            if (ph == PH_LEAD && c != CH_SPACE && c != CH_TAB)
                ph = PH_BOARD;
            case (ph)
                PH_LEAD: ;
                PH_BOARD:
                begin
                    if (files >= FILES_PER_RANK)
                    begin
                        if (rank != 3'd0)
                        begin
                            if (c != CH_SLASH)
                                e = ERR_SEPARATOR;
                            else
                            begin
                                rank  = rank - 3'd1;
                                files = 4'd0;
                            end
                        end
                        else if (c != CH_SPACE)
                            e = ERR_SPACE;
                        else
                            ph = PH_STM;
                    end
                    else if (c >= CH_ONE && c <= CH_EIGHT)
                    begin
                        files = files + 4'(dv);
                        if (files > FILES_PER_RANK)
                            e = ERR_FILES;
                    end
                    else
                    begin
                        hit = -1;
                        for (k = 0; k < 12; k++)
                            if (piece_chars[k] == c)
                                hit = k;
                        if (hit < 0)
                            e = ERR_SYMBOL;
                        else
                        begin
                            placed = 1'b1;
                            sq     = {rank, files[2:0]};
                            pc     = 4'(hit);
                            files  = files + 4'd1;
                        end
                    end
                end
                PH_STM:
                begin
                    if (c == CH_LC_W)
                        side = 1'b0;
                    else if (c == CH_LC_B)
                        side = 1'b1;
                    else
                        e = ERR_COLOR;
                    ph = PH_SP_STM;
                end
                PH_SP_STM:
                begin
                    if (c != CH_SPACE)
                        e = ERR_SPACE;
                    else
                        ph = PH_CASTLE;
                end
                PH_CASTLE:
                begin
                    if (castle_nxt == 3'd0 && c == CH_DASH)
                        castle_nxt = CASTLE_DONE;
                    else
                    begin
                        hit = -1;
                        for (k = int'(castle_nxt); k < 4; k++)
                            if (castle_chars[k] == c)
                                hit = k;
                        if (hit >= 0)
                        begin
                            castle[hit] = 1'b1;
                            castle_nxt  = 3'(hit + 1);
                        end
                        else if (castle_nxt == 3'd0)
                            e = ERR_CASTLE;
                        else if (c == CH_SPACE)
                            ph = PH_EP_FIRST;
                        else
                            e = ERR_SPACE;
                    end
                end
                PH_EP_FIRST:
                begin
                    if (c == CH_DASH)
                    begin
                        ep_on = 1'b0;
                        ph    = PH_SP_EP;
                    end
                    else if (c >= CH_LC_A && c <= CH_LC_H)
                    begin
                        ep_file = 3'(c - CH_LC_A);
                        ph      = PH_EP_RANK;
                    end
                    else
                        e = ERR_EPFILE;
                end
                PH_EP_RANK:
                begin
                    if (c == CH_THREE)
                        ep_rank = EP_RANK_WHITE;
                    else if (c == CH_SIX)
                        ep_rank = EP_RANK_BLACK;
                    else
                        e = ERR_EPRANK;
                    ep_on = 1'b1;
                    ph    = PH_SP_EP;
                end
                PH_SP_EP:
                begin
                    if (c != CH_SPACE)
                        e = ERR_SPACE;
                    else
                        ph = PH_HALF_FIRST;
                end
                PH_HALF_FIRST:
                begin
                    if (!is_dig)
                        e = ERR_HALFMOVE;
                    else
                    begin
                        half = 7'(dv);
                        ph   = (dv == 0) ? PH_SP_HALF : PH_HALF_SECOND;
                    end
                end
                PH_HALF_SECOND:
                begin
                    if (is_dig)
                    begin
                        half = 7'(half * 10 + dv);
                        ph   = PH_SP_HALF;
                    end
                    else if (c == CH_SPACE)
                        ph = PH_FULL_FIRST;
                    else
                        e = ERR_SPACE;
                end
                PH_SP_HALF:
                begin
                    if (c != CH_SPACE)
                        e = ERR_SPACE;
                    else
                        ph = PH_FULL_FIRST;
                end
                PH_FULL_FIRST:
                begin
                    if (!is_dig)
                        e = ERR_FULLMOVE;
                    else
                    begin
                        full = dv;
                        if (dv == 0 || la)
                            sum = 1'b1;
                        else
                            ph = PH_FULL_MORE;
                    end
                end
                PH_FULL_MORE:
                begin
                    if (!is_dig)
                        sum = 1'b1;
                    else
                    begin
                        v = full * 10 + dv;
                        if (full_sat || v > FM_MAX)
                        begin
                            full     = FM_MAX;
                            full_sat = 1'b1;
                        end
                        else
                            full = v;
                        if (la)
                            sum = 1'b1;
                    end
                end
                default: ph = PH_IDLE;
            endcase

            if (e != ERR_NONE)
            begin
                r.kind = KIND_ERROR;
                r.err  = e;
                ph     = PH_IDLE;
                emit   = 1'b1;
            end
            else if (sum)
            begin
                r.kind       = KIND_SUMMARY;
                r.side       = side;
                r.castle     = castle;
                r.ep_present = ep_on;
                r.ep_square  = ep_on ? {ep_rank, ep_file} : 6'd0;
                r.halfmove   = half;
                r.fullmove   = FULLMOVE_OUT_W'(full);
                r.sat        = full_sat;
                ph           = PH_IDLE;
                emit         = 1'b1;
            end
            else if (la && ph != PH_IDLE)
            begin
                r.kind = KIND_ERROR;
                r.err  = ERR_EARLY_END;
                ph     = PH_IDLE;
                emit   = 1'b1;
            end
            else if (placed)
            begin
                r.kind   = KIND_PLACE;
                r.square = sq;
                r.piece  = pc;
                emit     = 1'b1;
            end
        end
    endtask

    task automatic send_beat(input logic [7:0] c, input logic st, input logic la,
                             input bit use_fixed, input fen_result_t fixed);
        bit          got;
        fen_result_t pred;
        while (!calm && $urandom_range(0, 99) < 15)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= st;
        s_tlast  <= la;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_fen_char(c, st, la, got, pred);
        if (use_fixed)
            pending_results.push_back(fixed);
        else if (got)
            pending_results.push_back(pred);
        beats_sent++;
    endtask

    task automatic push_text(input string s);
        int         i;
        char_beat_t b;
        for (i = 0; i < s.len(); i++)
        begin
            b.ch    = s[i];
            b.start = 1'b0;
            b.last  = 1'b0;
            record_beats.push_back(b);
        end
    endtask

    task automatic build_record();
        int         rk;
        int         f;
        int         n;
        int         k;
        int         idx;
        logic [3:0] mask;
        logic [7:0] term;
        string      s;
        record_beats.delete();
        repeat ($urandom_range(0, 2))
            push_text($urandom_range(0, 1) ? " " : "\t");
        for (rk = 7; rk >= 0; rk--)
        begin
            if ($urandom_range(0, 1))
                push_text("8");
            else
            begin
                f = 0;
                while (f < 8)
                begin
                    if ($urandom_range(0, 2) == 0)
                    begin
                        n = $urandom_range(1, 8 - f);
                        push_text($sformatf("%0d", n));
                        f += n;
                    end
                    else
                    begin
                        s = " ";
                        s[0] = piece_chars[$urandom_range(0, 11)];
                        push_text(s);
                        f++;
                    end
                end
            end
            if (rk != 0)
                push_text("/");
        end
        push_text($urandom_range(0, 1) ? " w " : " b ");
        if ($urandom_range(0, 3) == 0)
            push_text("-");
        else
        begin
            mask = 4'($urandom_range(1, 15));
            for (k = 0; k < 4; k++)
                if (mask[k])
                begin
                    s = " ";
                    s[0] = castle_chars[k];
                    push_text(s);
                end
        end
        if ($urandom_range(0, 2) == 0)
            push_text(" - ");
        else
        begin
            s = " a3 ";
            s[1] = 8'(CH_LC_A + $urandom_range(0, 7));
            if ($urandom_range(0, 1))
                s[2] = CH_SIX;
            push_text(s);
        end
        case ($urandom_range(0, 2))
            0:       push_text("0 ");
            1:       push_text($sformatf("%0d ", $urandom_range(1, 9)));
            default: push_text($sformatf("%0d ", $urandom_range(10, 99)));
        endcase
        case ($urandom_range(0, 5))
            0:       push_text("0");
            1:       push_text($sformatf("%0d", $urandom_range(1, 9)));
            2:       push_text($sformatf("%0d", $urandom_range(10, 9999)));
            3:       push_text($sformatf("%0d", $urandom_range(60000, 70000)));
            4:       push_text("65535");
            default: push_text("9999999999");
        endcase
        if ($urandom_range(0, 1))
            record_beats[record_beats.size() - 1].last = 1'b1;
        else
        begin
            term = CH_SPACE;
            if ($urandom_range(0, 1))
                do
                    term = 8'($urandom_range(0, 255));
                while (term >= CH_ZERO && term <= CH_NINE);
            push_text(" ");
            record_beats[record_beats.size() - 1].ch   = term;
            record_beats[record_beats.size() - 1].last = ($urandom_range(0, 3) == 0);
        end
        record_beats[0].start = 1'b1;

        // corrupt, cut short, or end early on about a quarter of the records
        if ($urandom_range(0, 3) == 0)
        begin
            idx = $urandom_range(0, record_beats.size() - 1);
            case ($urandom_range(0, 2))
                0: record_beats[idx].ch = 8'($urandom_range(0, 255));
                1:
                begin
                    record_beats[idx].last = 1'b1;
                    while (record_beats.size() > idx + 1)
                        void'(record_beats.pop_back());
                end
                default:
                    while (record_beats.size() > idx + 1)
                        void'(record_beats.pop_back());
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        fen_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, got kind %0d data %h",
                         $time, m_tuser, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", want.kind, m_tuser);
                check_field("square", want.square, m_tdata[5:0]);
                check_field("piece", want.piece, m_tdata[9:6]);
                check_field("side_to_move", want.side, m_tdata[10]);
                check_field("castle_rights", want.castle, m_tdata[14:11]);
                check_field("ep_present", want.ep_present, m_tdata[15]);
                check_field("ep_square", want.ep_square, m_tdata[21:16]);
                check_field("halfmove_clock", want.halfmove, m_tdata[28:22]);
                check_field("fullmove_number", want.fullmove, m_tdata[44:29]);
                check_field("fullmove_saturated", want.sat, m_tdata[45]);
                check_field("error_code", want.err, m_tdata[49:46]);
                check_field("pad", 32'd0, m_tdata[55:50]);
            end
        end
    end

    initial
    begin : sink
        bit held;
        int stall;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && beats_sent >= 300)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                for (stall = 0; stall < HOLD_CYCLES; stall++)
                    @(posedge clk);
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 15);
        end
    end

    initial
    begin : source
        int          i;
        fen_result_t fixed;
        directed = '{
            '{"P",    1'b0, 1'b0, 1'b0, KIND_PLACE, ERR_NONE,      6'd0,  4'd0},
            '{" ",    1'b1, 1'b0, 1'b0, KIND_PLACE, ERR_NONE,      6'd0,  4'd0},
            '{CH_TAB, 1'b0, 1'b0, 1'b0, KIND_PLACE, ERR_NONE,      6'd0,  4'd0},
            '{"K",    1'b0, 1'b0, 1'b1, KIND_PLACE, ERR_NONE,      6'd56, 4'd5},
            '{"8",    1'b0, 1'b0, 1'b1, KIND_ERROR, ERR_FILES,     6'd0,  4'd0},
            '{"9",    1'b1, 1'b0, 1'b1, KIND_ERROR, ERR_SYMBOL,    6'd0,  4'd0},
            '{"8",    1'b1, 1'b0, 1'b0, KIND_PLACE, ERR_NONE,      6'd0,  4'd0},
            '{"8",    1'b0, 1'b0, 1'b1, KIND_ERROR, ERR_SEPARATOR, 6'd0,  4'd0},
            '{"k",    1'b1, 1'b1, 1'b1, KIND_ERROR, ERR_EARLY_END, 6'd0,  4'd0},
            '{8'hFF,  1'b1, 1'b0, 1'b1, KIND_ERROR, ERR_SYMBOL,    6'd0,  4'd0},
            '{8'h00,  1'b1, 1'b1, 1'b1, KIND_ERROR, ERR_SYMBOL,    6'd0,  4'd0},
            '{"p",    1'b1, 1'b0, 1'b1, KIND_PLACE, ERR_NONE,      6'd56, 4'd6},
            '{"7",    1'b0, 1'b0, 1'b0, KIND_PLACE, ERR_NONE,      6'd0,  4'd0},
            '{"/",    1'b0, 1'b0, 1'b0, KIND_PLACE, ERR_NONE,      6'd0,  4'd0},
            '{"q",    1'b0, 1'b0, 1'b1, KIND_PLACE, ERR_NONE,      6'd48, 4'd10},
            '{"/",    1'b0, 1'b1, 1'b1, KIND_ERROR, ERR_SYMBOL,    6'd0,  4'd0},
            '{"0",    1'b1, 1'b0, 1'b1, KIND_ERROR, ERR_SYMBOL,    6'd0,  4'd0},
            '{"Q",    1'b0, 1'b0, 1'b0, KIND_PLACE, ERR_NONE,      6'd0,  4'd0},
            '{"8",    1'b1, 1'b0, 1'b0, KIND_PLACE, ERR_NONE,      6'd0,  4'd0},
            '{"/",    1'b0, 1'b1, 1'b1, KIND_ERROR, ERR_EARLY_END, 6'd0,  4'd0}
        };
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            fixed        = '0;
            fixed.kind   = directed[i].kind;
            fixed.err    = directed[i].err;
            fixed.square = directed[i].square;
            fixed.piece  = directed[i].piece;
            send_beat(directed[i].ch, directed[i].start, directed[i].last,
                      directed[i].typed, fixed);
        end

        while (beats_sent < DIRECTED_ROWS + RANDOM_BEATS)
        begin
            // stray characters between records
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3))
                    send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
            build_record();
            for (i = 0; i < record_beats.size(); i++)
                send_beat(record_beats[i].ch, record_beats[i].start, record_beats[i].last,
                          1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS fen_position_parser");
        else
            $display("FAIL fen_position_parser");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL fen_position_parser");
        $finish;
    end

endmodule
